FILE: rtl/pwfb_pkg.sv
// ----------------------------------------------------------------------------
// pwfb_pkg
// Shared widths, request and status codes, and the command/status bundles
// that join the page window flag bitmap controller and datapath.
// ----------------------------------------------------------------------------
package pwfb_pkg;

   localparam int MAX_PAGES_DEF = 4096;
   localparam int ADDR_BITS_DEF = 48;

   localparam int ADDR_W     = 48;
   localparam int PAGE_W     = 12;
   localparam int COUNT_W    = 13;
   localparam int SHIFT_W    = 5;
   localparam int TYPE_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int RESULT_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam int WORD_BITS  = 64;
   localparam int BIT_IDX_W  = 6;

   localparam logic [SHIFT_W-1:0] RESET_SHIFT = 5'd12;

   localparam logic [TYPE_W-1:0] REQ_FREE  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_ZERO  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_SET   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_TEST  = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_INIT  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_SHIFT  = 2'd2;

   typedef struct packed {
      logic capture;
      logic decode;
      logic test_chk;
      logic sweep_wr;
      logic range_rd;
      logic load_first;
      logic load_zero;
      logic advance;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic need_sweep;
      logic need_range;
      logic need_test;
      logic sweep_last;
      logic range_last;
      logic rsp_free;
   } stat_type;

   function automatic int idx_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

FILE: rtl/pwfb_if.sv
// ----------------------------------------------------------------------------
// pwfb_if
// Request and response channels of the page window flag bitmap: valid/ready
// handshake with the word payload.
// ----------------------------------------------------------------------------
interface pwfb_req_if import pwfb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [PAGE_W-1:0]   first_page;
   logic [PAGE_W-1:0]   last_page;
   logic [ADDR_W-1:0]   address;

   modport source (output valid, req_type, first_page, last_page, address, input ready);
   modport sink   (input valid, req_type, first_page, last_page, address, output ready);
endinterface

interface pwfb_rsp_if import pwfb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [RESULT_W-1:0] test_result;

   modport source (output valid, status, test_result, input ready);
   modport sink   (input valid, status, test_result, output ready);
endinterface

FILE: rtl/page_window_flag_bitmap_unit.sv
// ----------------------------------------------------------------------------
// page_window_flag_bitmap_unit
// One flag bit per page over a configured address window: init, free, zero,
// range set/clear and address test requests, one response word each.
//
//   port      dir   handshake      payload
//   req_chan  in    valid/ready    req_type, first_page, last_page, address
//   rsp_chan  out   valid/ready    status, test_result
//   csr_*     in    write enable   csr_index, csr_write_data
//
// Each accepted request is decoded, then worked, then its response is loaded.
// Free, unused types, reversed ranges and rejected requests go straight to
// the response; a test of a present map does the address subtract/shift in
// decode, then one RAM read; set/clear does one read-modify-write of the
// bitmap RAM per word spanned; init and zero clear one word per cycle.
// The next request is taken the cycle after the response is loaded into the
// output register. A stalled response holds; the next response waits for it.
// Reset needs no clearing pass: the map is absent until an init clears it.
// ----------------------------------------------------------------------------
module page_window_flag_bitmap_unit import pwfb_pkg::*; #(
   parameter int MAX_PAGES = MAX_PAGES_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pwfb_req_if.sink              req_chan,
   pwfb_rsp_if.source            rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   pwfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pwfb_dpath #(
      .MAX_PAGES (MAX_PAGES),
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_type        (req_chan.req_type),
      .first_page      (req_chan.first_page),
      .last_page       (req_chan.last_page),
      .address         (req_chan.address),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_test_result (rsp_chan.test_result)
   );

   assign req_chan.ready = req_ready;

endmodule

FILE: rtl/pwfb_ram.sv
// ----------------------------------------------------------------------------
// pwfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwfb_ram import pwfb_pkg::*; #(
   parameter int WIDTH = WORD_BITS,
   parameter int DEPTH = MAX_PAGES_DEF / WORD_BITS
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [idx_width(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]            wr_data,
   input  logic                        rd_en,
   input  logic [idx_width(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pwfb_ctrl.sv
// ----------------------------------------------------------------------------
// pwfb_ctrl
// Request sequencer: decode, bitmap sweep, range read-modify-write walk,
// test lookup and response hand-off.
// ----------------------------------------------------------------------------
module pwfb_ctrl import pwfb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DECODE   = 7'b0000010,
      S_SWEEP    = 7'b0000100,
      S_RANGE_RD = 7'b0001000,
      S_RANGE_WB = 7'b0010000,
      S_TEST_CHK = 7'b0100000,
      S_FINISH   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.need_sweep) begin
               cmd.load_zero = 1'b1;
               state_in      = S_SWEEP;
            end else if (stat.need_range) begin
               cmd.load_first = 1'b1;
               state_in       = S_RANGE_RD;
            end else if (stat.need_test) begin
               state_in = S_TEST_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            cmd.advance  = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_RANGE_RD: begin
            cmd.range_rd = 1'b1;
            cmd.advance  = 1'b1;
            if (stat.range_last) begin
               state_in = S_RANGE_WB;
            end
         end
         S_RANGE_WB: begin
            // last modified word is written back this cycle
            state_in = S_FINISH;
         end
         S_TEST_CHK: begin
            cmd.test_chk = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(req_ready) |-> $past(cmd.load_rsp))
      else $error("request side reopened without a response load");

   a_decode_follows_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.decode |-> $past(cmd.capture))
      else $error("decode without a captured word");

endmodule

FILE: rtl/pwfb_dpath.sv
// ----------------------------------------------------------------------------
// pwfb_dpath
// Configuration registers, request registers, presence flag, bitmap RAM with
// its word counter and range masks, test page lookup and response register.
// ----------------------------------------------------------------------------
module pwfb_dpath import pwfb_pkg::*; #(
   parameter int MAX_PAGES = MAX_PAGES_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   input  logic                       csr_write_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data,
   input  logic [TYPE_W-1:0]          req_type,
   input  logic [PAGE_W-1:0]          first_page,
   input  logic [PAGE_W-1:0]          last_page,
   input  logic [ADDR_W-1:0]          address,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [RESULT_W-1:0] rsp_test_result
);

   localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WW     = idx_width(NWORDS);
   localparam int AW     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int CW     = $clog2(MAX_PAGES + 1);
   localparam int LW     = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int PW     = (WW + BIT_IDX_W > PAGE_W) ? WW + BIT_IDX_W : PAGE_W;

   typedef enum logic [1:0] {
      KIND_ZERO = 2'd0,
      KIND_NEG  = 2'd1,
      KIND_BIT  = 2'd2
   } kind_type;

   // configuration
   logic [ADDR_W-1:0]  base_ff,  base_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;

   // request
   logic [TYPE_W-1:0]  type_ff,  type_in;
   logic [PAGE_W-1:0]  first_ff, first_in;
   logic [PAGE_W-1:0]  last_ff,  last_in;
   logic [ADDR_W-1:0]  addr_ff,  addr_in;

   logic               present_ff, present_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   kind_type           kind_ff,  kind_in;
   logic [AW-1:0]      id_ff,    id_in;
   logic               below_ff, below_in;
   logic [WW-1:0]      word_ff,  word_in;
   logic               pend_ff,  pend_in;
   logic [WW-1:0]      pend_word_ff, pend_word_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [RESULT_W-1:0] rsp_result_ff, rsp_result_in;

   logic [LW-1:0]        count_ext;
   logic [LW-1:0]        live_count;
   logic                 first_ok;
   logic                 last_ok;
   logic                 is_range;
   logic                 range_legal;
   logic [PW-1:0]        first_x;
   logic [PW-1:0]        last_x;
   logic [WW-1:0]        first_word;
   logic [WW-1:0]        last_word;
   logic [AW:0]          addr_diff;
   logic                 in_window;
   logic [BIT_IDX_W-1:0] lo_bit;
   logic [BIT_IDX_W-1:0] hi_bit;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] rd_data;
   logic                 rd_en;
   logic [WW-1:0]        rd_addr;
   logic                 wr_en;
   logic [WW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic signed [RESULT_W-1:0] test_value;

   // page count above the map size acts as the map size
   assign count_ext  = LW'(count_ff);
   assign live_count = (count_ext > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : count_ext;
   assign first_ok   = LW'(first_ff) < live_count;
   assign last_ok    = LW'(last_ff) < live_count;
   assign is_range   = type_ff inside {REQ_CLEAR, REQ_SET};
   assign range_legal = first_ok && last_ok;
   assign first_x    = PW'(first_ff);
   assign last_x     = PW'(last_ff);
   assign first_word = first_x[WW+BIT_IDX_W-1:BIT_IDX_W];
   assign last_word  = last_x[WW+BIT_IDX_W-1:BIT_IDX_W];

   assign addr_diff = {1'b0, addr_ff[AW-1:0]} - {1'b0, base_ff[AW-1:0]};
   assign in_window = !below_ff && (id_ff < AW'(live_count));

   // bit mask of the range inside the word now being written back
   assign lo_bit   = (pend_word_ff == first_word) ? first_x[BIT_IDX_W-1:0] : '0;
   assign hi_bit   = (pend_word_ff == last_word) ? last_x[BIT_IDX_W-1:0] : '1;
   assign mask     = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (~hi_bit));
   assign new_word = (type_ff == REQ_SET) ? (rd_data | mask) : (rd_data & ~mask);

   assign rd_en   = cmd.range_rd || cmd.test_chk;
   assign rd_addr = cmd.test_chk ? id_ff[WW+BIT_IDX_W-1:BIT_IDX_W] : word_ff;
   assign wr_en   = cmd.sweep_wr || pend_ff;
   assign wr_addr = cmd.sweep_wr ? word_ff : pend_word_ff;
   assign wr_data = cmd.sweep_wr ? '0 : new_word;

   always_comb begin
      case (kind_ff)
         KIND_BIT: test_value = {1'b0, rd_data[id_ff[BIT_IDX_W-1:0]]};
         KIND_NEG: test_value = '1;
         default:  test_value = '0;
      endcase
   end

   assign stat.need_sweep = (type_ff == REQ_INIT) || ((type_ff == REQ_ZERO) && present_ff);
   assign stat.need_range = is_range && present_ff && range_legal && (first_ff <= last_ff);
   assign stat.need_test  = (type_ff == REQ_TEST) && present_ff;
   assign stat.sweep_last = word_ff == WW'(NWORDS - 1);
   assign stat.range_last = word_ff == last_word;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_BASE: base_in  = csr_write_data[ADDR_W-1:0];
            CSR_PAGE_COUNT:  count_in = csr_write_data[COUNT_W-1:0];
            CSR_SIZE_SHIFT:  shift_in = csr_write_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      type_in  = cmd.capture ? req_type   : type_ff;
      first_in = cmd.capture ? first_page : first_ff;
      last_in  = cmd.capture ? last_page  : last_ff;
      addr_in  = cmd.capture ? address    : addr_ff;

      present_in = present_ff;
      status_in  = status_ff;
      kind_in    = kind_ff;
      id_in      = id_ff;
      below_in   = below_ff;
      if (cmd.decode) begin
         id_in    = addr_diff[AW-1:0] >> shift_ff;
         below_in = addr_diff[AW];
         kind_in  = KIND_ZERO;
         case (type_ff)
            REQ_FREE: begin
               status_in  = present_ff ? STATUS_DONE : STATUS_ABSENT;
               present_in = 1'b0;
            end
            REQ_ZERO: begin
               status_in = present_ff ? STATUS_DONE : STATUS_ABSENT;
            end
            REQ_CLEAR, REQ_SET: begin
               if (!present_ff) begin
                  status_in = STATUS_ABSENT;
               end else if (!range_legal) begin
                  status_in = STATUS_RANGE;
               end else begin
                  status_in = STATUS_DONE;
               end
            end
            REQ_TEST: begin
               status_in = present_ff ? STATUS_DONE : STATUS_ABSENT;
               kind_in   = KIND_NEG;
            end
            REQ_INIT: begin
               status_in  = STATUS_DONE;
               present_in = 1'b1;
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
      if (cmd.test_chk) begin
         kind_in = in_window ? KIND_BIT : KIND_NEG;
      end

      word_in = word_ff;
      if (cmd.load_zero) begin
         word_in = '0;
      end else if (cmd.load_first) begin
         word_in = first_word;
      end else if (cmd.advance) begin
         word_in = word_ff + WW'(1);
      end
      pend_in      = cmd.range_rd;
      pend_word_in = cmd.range_rd ? word_ff : pend_word_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_result_in = rsp_result_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_result_in = test_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         count_ff     <= '0;
         shift_ff     <= RESET_SHIFT;
         present_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         present_ff   <= present_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      addr_ff       <= addr_in;
      status_ff     <= status_in;
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      below_ff      <= below_in;
      word_ff       <= word_in;
      pend_word_ff  <= pend_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
   end

   pwfb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NWORDS)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_test_result = rsp_result_ff;

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response word overwritten while stalled");

   a_range_write_present: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> present_ff)
      else $error("range write-back with the map absent");

   a_range_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.range_rd |-> (word_ff <= last_word))
      else $error("range walk ran past the last word");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_wr |-> !pend_ff)
      else $error("sweep and range write-back collide");

endmodule

FILE: bench/page_window_flag_bitmap_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_window_flag_bitmap_unit_test
// Drives request words into the page window flag bitmap under a series of
// window settings and checks every response word against a predictor of the
// flag map, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module page_window_flag_bitmap_unit_test;
   import pwfb_pkg::*;

   localparam logic [TYPE_W-1:0]    REQ_RSVD6  = 3'd6;
   localparam logic [TYPE_W-1:0]    REQ_RSVD7  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [RESULT_W-1:0] TEST_NONE    = 2'sd0;
   localparam logic signed [RESULT_W-1:0] TEST_FLAGGED = 2'sd1;
   localparam logic signed [RESULT_W-1:0] TEST_OUTSIDE = -2'sd1;

   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 75;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [PAGE_W-1:0] first_page;
      logic [PAGE_W-1:0] last_page;
      logic [ADDR_W-1:0] address;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [RESULT_W-1:0] test_result;
   } rsp_word_type;

   // Flag map predictor plus the queue of response words still owed.
   class bitmap_scoreboard;
      bit [MAX_PAGES_DEF-1:0] flags;
      bit                     present;
      logic [ADDR_W-1:0]      base;
      logic [COUNT_W-1:0]     count;
      logic [SHIFT_W-1:0]     shift;
      rsp_word_type           owed_q[$];
      int                     errors;
      int                     checked;

      function new();
         flags   = '0;
         present = 1'b0;
         base    = '0;
         count   = '0;
         shift   = RESET_SHIFT;
         errors  = 0;
         checked = 0;
      endfunction

      function logic [COUNT_W-1:0] live_count();
         return (count > COUNT_W'(MAX_PAGES_DEF)) ? COUNT_W'(MAX_PAGES_DEF) : count;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_WINDOW_BASE: base  = data[ADDR_W-1:0];
            CSR_PAGE_COUNT:  count = data[COUNT_W-1:0];
            CSR_SIZE_SHIFT:  shift = data[SHIFT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type       e;
         logic [COUNT_W-1:0] cnt;
         logic [ADDR_W-1:0]  pid;
         e.status      = STATUS_DONE;
         e.test_result = TEST_NONE;
         cnt = live_count();
         case (w.req_type)
            REQ_FREE: begin
               if (present) begin
                  flags   = '0;
                  present = 1'b0;
               end else e.status = STATUS_ABSENT;
            end
            REQ_ZERO: begin
               if (present) flags = '0;
               else e.status = STATUS_ABSENT;
            end
            REQ_CLEAR, REQ_SET: begin
               if (!present) e.status = STATUS_ABSENT;
               else if (w.first_page >= cnt || w.last_page >= cnt) e.status = STATUS_RANGE;
               else begin
                  for (int p = int'(w.first_page); p <= int'(w.last_page); p++)
                     flags[p] = (w.req_type == REQ_SET);
               end
            end
            REQ_TEST: begin
               e.test_result = TEST_OUTSIDE;
               if (!present) e.status = STATUS_ABSENT;
               else if (w.address >= base) begin
                  pid = (w.address - base) >> shift;
                  if (pid < cnt)
                     e.test_result = flags[pid[PAGE_W-1:0]] ? TEST_FLAGGED : TEST_NONE;
               end
            end
            REQ_INIT: begin
               flags   = '0;
               present = 1'b1;
            end
            default: ;
         endcase
         owed_q.push_back(e);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic signed [RESULT_W-1:0] test_result);
         rsp_word_type e;
         if (owed_q.size() == 0) begin
            $display("%0t unexpected response word: status %0d test_result %0d",
                     $time, status, test_result);
            errors++;
            return;
         end
         e = owed_q.pop_front();
         checked++;
         if (status !== e.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time, e.status, status);
            errors++;
         end
         if (test_result !== e.test_result) begin
            $display("%0t test_result mismatch: expected %0d actual %0d",
                     $time, e.test_result, test_result);
            errors++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void report_leftovers();
         if (owed_q.size() != 0) begin
            $display("%0t %0d response words never arrived", $time, owed_q.size());
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pwfb_req_if req_chan();
   pwfb_rsp_if rsp_chan();

   page_window_flag_bitmap_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   bitmap_scoreboard sb = new();

   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int recent_page = 0;
   int stall_mode  = 0;
   int stall_tick  = 0;
   int stall_hold  = 0;
   int settings    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: take words, then pick ready from the current stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response(rsp_chan.status, rsp_chan.test_result);
      stall_tick++;
      if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2: rsp_chan.ready <= (stall_tick % 4 == 0);
         default: begin
            if (stall_hold > 0) begin
               stall_hold--;
               rsp_chan.ready <= 1'b0;
            end else begin
               stall_hold = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
               rsp_chan.ready <= 1'b1;
            end
         end
      endcase
   end

   function automatic logic [ADDR_W-1:0] rand48();
      logic [31:0] hi;
      logic [31:0] lo;
      hi = $urandom;
      lo = $urandom;
      return {hi[15:0], lo};
   endfunction

   function automatic req_word_type mk(logic [TYPE_W-1:0] t, logic [PAGE_W-1:0] f,
                                       logic [PAGE_W-1:0] l, logic [ADDR_W-1:0] a);
      req_word_type w;
      w.req_type   = t;
      w.first_page = f;
      w.last_page  = l;
      w.address    = a;
      return w;
   endfunction

   // Mostly well-formed work on a present map, with some noise mixed in.
   function automatic req_word_type gen_item();
      req_word_type w;
      int           roll;
      int           c;
      int           span;
      int           lo;
      logic [63:0]  pid;
      logic [63:0]  offs;
      c = int'(sb.live_count());
      w = mk(REQ_TEST, PAGE_W'($urandom), PAGE_W'($urandom), rand48());
      roll = $urandom_range(0, 99);
      if (!sb.present && $urandom_range(0, 9) < 4) roll = 83;
      if (roll < 45) begin
         w.req_type = (roll < 30) ? REQ_SET : REQ_CLEAR;
         if (c != 0) begin
            w.first_page = PAGE_W'($urandom_range(0, c - 1));
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, c - 1)
                                                : $urandom_range(0, 70);
            lo = int'(w.first_page);
            w.last_page = PAGE_W'((lo + span > c - 1) ? c - 1 : lo + span);
            if (w.req_type == REQ_SET) recent_page = lo;
         end
      end else if (roll < 80) begin
         pid = $urandom_range(0, 1) ? 64'(recent_page + $urandom_range(0, 3))
                                    : 64'($urandom_range(0, c + 1));
         offs = 64'(rand48()) & ((64'd1 << sb.shift) - 64'd1);
         w.address = ADDR_W'(64'(sb.base) + (pid << sb.shift) + offs);
      end else if (roll < 83) w.req_type = REQ_ZERO;
      else if (roll < 85) w.req_type = REQ_INIT;
      else if (roll < 86) w.req_type = REQ_FREE;
      else if (roll < 92) w.req_type = $urandom_range(0, 1) ? REQ_SET : REQ_CLEAR;
      else if (roll < 96) w.req_type = REQ_TEST;
      else if (roll < 98) w.req_type = (roll == 96) ? REQ_RSVD6 : REQ_RSVD7;
      else begin
         w.req_type = $urandom_range(0, 1) ? REQ_SET : REQ_CLEAR;
         if (c > 1) begin
            w.last_page  = PAGE_W'($urandom_range(0, c - 2));
            w.first_page = PAGE_W'($urandom_range(int'(w.last_page) + 1, c - 1));
         end
      end
      return w;
   endfunction

   // Hold valid until the word is taken; end a burst with a random gap.
   task automatic issue(input req_word_type w);
      int gap;
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= w.req_type;
      req_chan.first_page <= w.first_page;
      req_chan.last_page  <= w.last_page;
      req_chan.address    <= w.address;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(w);
      items_sent++;
      if (burst_left > 0) burst_left--;
      else begin
         gap = $urandom_range(0, 10);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 20);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Idle the block, then load a window; junk fills the bits above each field.
   task automatic configure(input logic [ADDR_W-1:0] b, input logic [COUNT_W-1:0] c,
                            input logic [SHIFT_W-1:0] s, input bit junk,
                            input bit poke_unused);
      logic [CSR_DATA_W-1:0] d;
      drain();
      write_csr(CSR_WINDOW_BASE, b);
      d = junk ? rand48() : '0;
      d[COUNT_W-1:0] = c;
      write_csr(CSR_PAGE_COUNT, d);
      d = junk ? rand48() : '0;
      d[SHIFT_W-1:0] = s;
      write_csr(CSR_SIZE_SHIFT, d);
      if (poke_unused) write_csr(CSR_UNUSED, rand48());
      csr_write_en <= 1'b0;
      settings++;
   endtask

   initial begin
      reset               <= 1'b1;
      csr_write_en        <= 1'b0;
      csr_index           <= '0;
      csr_write_data      <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= '0;
      req_chan.first_page <= '0;
      req_chan.last_page  <= '0;
      req_chan.address    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // absent map under reset settings, unused types, count of zero
      issue(mk(REQ_TEST, '0, '0, '0));
      issue(mk(REQ_SET, '0, '0, '0));
      issue(mk(REQ_CLEAR, '1, '1, '1));
      issue(mk(REQ_FREE, '0, '0, '0));
      issue(mk(REQ_ZERO, '0, '0, '0));
      issue(mk(REQ_RSVD6, '1, '1, '1));
      issue(mk(REQ_RSVD7, '0, '0, '0));
      issue(mk(REQ_INIT, '0, '0, '0));
      issue(mk(REQ_SET, '0, '0, '0));
      issue(mk(REQ_TEST, '0, '0, '0));

      // full window: whole-map set, edges of the map, reversed range, zero, free
      configure('0, 13'd4096, 5'd12, 1'b0, 1'b1);
      issue(mk(REQ_INIT, '0, '0, '0));
      issue(mk(REQ_SET, '0, '1, '0));
      issue(mk(REQ_TEST, '0, '0, '0));
      issue(mk(REQ_TEST, '0, '0, '1));
      issue(mk(REQ_CLEAR, '1, '1, '0));
      issue(mk(REQ_TEST, '0, '0, 48'h0000_00FF_F000));
      issue(mk(REQ_TEST, '0, '0, 48'h0000_00FF_EFFF));
      issue(mk(REQ_CLEAR, 12'd10, 12'd5, '0));
      issue(mk(REQ_TEST, '0, '0, 48'h0000_0000_5000));
      issue(mk(REQ_ZERO, '0, '0, '0));
      issue(mk(REQ_TEST, '0, '0, 48'h0000_0000_7000));
      issue(mk(REQ_FREE, '0, '0, '0));
      issue(mk(REQ_TEST, '0, '0, 48'h0000_0000_7000));

      // short window at a high base: range ends at and past the count
      configure(48'hFFFF_FFFF_F000, 13'd100, 5'd0, 1'b0, 1'b0);
      issue(mk(REQ_INIT, '0, '0, '0));
      issue(mk(REQ_SET, 12'd99, 12'd99, '0));
      issue(mk(REQ_SET, 12'd99, 12'd100, '0));
      issue(mk(REQ_CLEAR, 12'd100, 12'd0, '0));
      issue(mk(REQ_TEST, '0, '0, 48'hFFFF_FFFF_F063));
      issue(mk(REQ_TEST, '0, '0, 48'hFFFF_FFFF_F064));
      issue(mk(REQ_TEST, '0, '0, 48'hFFFF_FFFF_EFFF));

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: configure('0, 13'd4096, 5'd12, 1'b0, 1'b0);
            1: configure(rand48(), 13'd4096, 5'd0, 1'b1, 1'b0);
            2: configure('1, 13'd4096, 5'd0, 1'b0, 1'b0);
            3: configure(rand48(), 13'd1, 5'd31, 1'b1, 1'b1);
            4: configure(rand48(), 13'd8191, 5'd30, 1'b0, 1'b0);
            5: configure(rand48(), 13'd0, SHIFT_W'($urandom_range(0, 31)), 1'b1, 1'b0);
            default: configure(rand48(), COUNT_W'($urandom_range(1, 4096)),
                               SHIFT_W'($urandom_range(0, 31)),
                               1'($urandom_range(0, 1)), 1'b0);
         endcase
         // keep the old flags now and then, so the new window applies to them live
         if (ph == 0 || $urandom_range(0, 1)) issue(mk(REQ_INIT, '0, '0, '0));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            issue(gen_item());
            if ((ph == 0 && i == 40) || $urandom_range(0, 199) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.report_leftovers();
      $display("%0d request words sent over %0d window settings, %0d responses checked",
               items_sent, settings, sb.checked);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d errors", sb.errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: page_window_flag_bitmap_unit.f
rtl/pwfb_pkg.sv
rtl/pwfb_if.sv
rtl/pwfb_ram.sv
rtl/pwfb_ctrl.sv
rtl/pwfb_dpath.sv
rtl/page_window_flag_bitmap_unit.sv
bench/page_window_flag_bitmap_unit_test.sv
